// ===== rtl/core/sitda_pkg.sv =====
`default_nettype none

package sitda_pkg;

    localparam int unsigned BinWidth  = 32;
    localparam int unsigned NumDigits = 10;
    localparam int unsigned CntWidth  = $clog2(BinWidth);
    localparam int unsigned IdxWidth  = $clog2(NumDigits);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef logic [NumDigits-1:0][3:0] bcd_t;

    typedef struct packed {
        bcd_t digits;
        logic neg;
    } conv_result_t;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_SHIFT,
        CV_DONE
    } conv_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_MINUS,
        EM_DIGIT
    } emit_state_t;

    // Index of the most significant nonzero digit; zero maps to the ones digit.
    function automatic logic [IdxWidth-1:0] msd_index(input bcd_t digits);
        logic [IdxWidth-1:0] idx;
        idx = '0;
        for (int i = 0; i < NumDigits; i++)
        begin
            if (digits[i] != 4'd0)
            begin
                idx = IdxWidth'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sitda_bcd_conv.sv =====
`default_nettype none

module sitda_bcd_conv
    import sitda_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start_valid,
    output logic                     start_ready,
    input  wire logic [BinWidth-1:0] mag,
    input  wire logic                neg,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output conv_result_t             res
);

    conv_state_t            state_reg, state_next;
    logic [CntWidth-1:0]    cnt_reg, cnt_next;
    logic [BinWidth-1:0]    bin_reg, bin_next;
    bcd_t                   bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;
    bcd_t                   bcd_adj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    // Each digit of at least five is corrected by three before the shift.
    always_comb
    begin
        for (int i = 0; i < NumDigits; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        neg_next    = neg_reg;
        start_ready = 1'b0;
        res_valid   = 1'b0;
        unique case (state_reg)
            CV_IDLE:
            begin
                start_ready = 1'b1;
                if (start_valid)
                begin
                    bin_next   = mag;
                    bcd_next   = '0;
                    neg_next   = neg;
                    cnt_next   = '0;
                    state_next = CV_SHIFT;
                end
            end
            CV_SHIFT:
            begin
                bcd_next = bcd_t'({bcd_adj, bin_reg[BinWidth-1]});
                bin_next = {bin_reg[BinWidth-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntWidth'(BinWidth - 1))
                begin
                    state_next = CV_DONE;
                end
            end
            CV_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    assign res.digits = bcd_reg;
    assign res.neg    = neg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sitda_char_emit.sv =====
`default_nettype none

module sitda_char_emit
    import sitda_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load_valid,
    output logic               load_ready,
    input  wire conv_result_t  load,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_char,
    output logic               out_last
);

    emit_state_t            state_reg, state_next;
    logic                   valid_reg, valid_next;
    logic [7:0]             char_reg, char_next;
    logic                   last_reg, last_next;
    bcd_t                   bcd_reg, bcd_next;
    logic [IdxWidth-1:0]    idx_reg, idx_next;
    logic                   advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        bcd_reg  <= bcd_next;
        idx_reg  <= idx_next;
    end

    assign advance = !valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        bcd_next   = bcd_reg;
        idx_next   = idx_reg;
        load_ready = 1'b0;
        if (advance)
        begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            EM_IDLE:
            begin
                load_ready = 1'b1;
                if (load_valid)
                begin
                    bcd_next   = load.digits;
                    idx_next   = msd_index(load.digits);
                    state_next = load.neg ? EM_MINUS : EM_DIGIT;
                end
            end
            EM_MINUS:
            begin
                if (advance)
                begin
                    valid_next = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = EM_DIGIT;
                end
            end
            EM_DIGIT:
            begin
                if (advance)
                begin
                    valid_next = 1'b1;
                    char_next  = CHAR_ZERO + {4'd0, bcd_reg[idx_reg]};
                    last_next  = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = EM_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/signed_int_to_decimal_ascii_unit.sv =====
// The first character is valid after the bit-serial binary to BCD shifter has
// finished; characters then leave one per cycle, up to eleven, while out_ready is high.
// The shifter takes one input bit per cycle, and a new transaction is accepted
// only after the previous result has been handed to the character stage.
// Reset (rst_n, asynchronous, active low) empties both stages and the output.
`default_nettype none

module signed_int_to_decimal_ascii_unit
    import sitda_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              character,
    output logic                    is_last
);

    logic [BinWidth-1:0] mag;
    logic                neg;
    logic                res_valid;
    logic                res_ready;
    conv_result_t        res;

    assign neg = value[31];
    assign mag = neg ? (32'd0 - $unsigned(value)) : $unsigned(value);

    sitda_bcd_conv u_conv (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_valid (in_valid),
        .start_ready (in_ready),
        .mag         (mag),
        .neg         (neg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    sitda_char_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (res_valid),
        .load_ready (res_ready),
        .load       (res),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (character),
        .out_last   (is_last)
    );

`ifndef ASSERT_OFF
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (character == CHAR_MINUS) ||
                      ((character >= CHAR_ZERO) && (character <= CHAR_ZERO + 8'd9)))
        else $error("character outside the sign and digit codes");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (character == CHAR_MINUS)) |-> !is_last)
        else $error("sign character flagged as last");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("converter ready right after accepting a transaction");
`endif

endmodule

`default_nettype wire
